### sv/sawl_pkg.sv
// Package for the stop-and-wait ARQ link: operation codes, timer constants
// and the result flag record passed from the controller to the output stage.
// Depends on nothing.
package sawl_pkg;

   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_FRAME  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam int TIMER_BITS = 16;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX     = {TIMER_BITS{1'b1}};
   localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = 16'd5;

   typedef struct packed {
      logic link_valid;
      logic link_is_ack;
      logic link_seq;
      logic link_from_ram;
      logic deliver_valid;
      logic dropped;
   } result_flags_type;

endpackage

### sv/sawl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the send queue; depends on nothing.
module sawl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sawl_ctrl.sv
// Sender and receiver state of the stop-and-wait ARQ link: queue pointers,
// sequence bits, retransmit timer and the per-request decision.
// Depends on sawl_pkg.
module sawl_ctrl #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32,
   localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        operation,
   input  logic                              frame_is_ack,
   input  logic                              frame_seq,
   input  logic [PAYLOAD_BITS-1:0]           payload,
   input  logic                              csr_write_enable,
   input  logic [sawl_pkg::TIMER_BITS-1:0]   csr_write_data,
   output sawl_pkg::result_flags_type        flags,
   output logic [PAYLOAD_BITS-1:0]           link_payload,
   output logic [PAYLOAD_BITS-1:0]           deliver_payload,
   output logic                              wr_en,
   output logic [ADDR_BITS-1:0]              wr_addr,
   output logic [PAYLOAD_BITS-1:0]           wr_data,
   output logic                              rd_en,
   output logic [ADDR_BITS-1:0]              rd_addr
);

   import sawl_pkg::*;

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS   = ADDR_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);
   localparam logic [SUM_BITS-1:0]   DEPTH_SUM  = SUM_BITS'(QUEUE_DEPTH);
   localparam logic [ADDR_BITS-1:0]  LAST_ADDR  = ADDR_BITS'(QUEUE_DEPTH - 1);

   logic [TIMER_BITS-1:0] timeout_ff, timeout_in;
   logic [ADDR_BITS-1:0]  head_ff, head_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  tx_seq_ff, tx_seq_in;
   logic                  in_flight_ff, in_flight_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  ack_seen_ff, ack_seen_in;
   logic                  ack_bit_ff, ack_bit_in;
   logic                  data_seen_ff, data_seen_in;
   logic                  data_bit_ff, data_bit_in;
   logic                  rx_bit_ff, rx_bit_in;

   logic [SUM_BITS-1:0]   tail_sum;
   logic [ADDR_BITS-1:0]  tail_addr;
   logic [ADDR_BITS-1:0]  head_next;
   logic [TIMER_BITS-1:0] timer_inc;

   always_comb begin
      tail_sum = SUM_BITS'(head_ff) + SUM_BITS'(count_ff);
      if (tail_sum >= DEPTH_SUM) begin
         tail_sum = tail_sum - DEPTH_SUM;
      end
      tail_addr = tail_sum[ADDR_BITS-1:0];
      head_next = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
      timer_inc = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + 1'b1;
   end

   always_comb begin
      timeout_in      = csr_write_enable ? csr_write_data : timeout_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      tx_seq_in       = tx_seq_ff;
      in_flight_in    = in_flight_ff;
      timer_in        = timer_ff;
      ack_seen_in     = ack_seen_ff;
      ack_bit_in      = ack_bit_ff;
      data_seen_in    = data_seen_ff;
      data_bit_in     = data_bit_ff;
      rx_bit_in       = rx_bit_ff;
      flags           = '0;
      link_payload    = '0;
      deliver_payload = '0;
      wr_en           = 1'b0;
      wr_addr         = tail_addr;
      wr_data         = payload;
      rd_en           = 1'b0;
      rd_addr         = head_ff;
      if (accept) begin
         case (operation)
            OP_PACKET: begin
               if (count_ff == COUNT_FULL) begin
                  flags.dropped = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (!in_flight_ff) begin
                     flags.link_valid = 1'b1;
                     flags.link_seq   = tx_seq_ff;
                     link_payload     = payload;
                     in_flight_in     = 1'b1;
                     timer_in         = '0;
                  end
               end
            end
            OP_FRAME: begin
               if (frame_is_ack) begin
                  if (in_flight_ff && count_ff != '0 &&
                      (!ack_seen_ff || ack_bit_ff != frame_seq)) begin
                     ack_seen_in  = 1'b1;
                     ack_bit_in   = frame_seq;
                     head_in      = head_next;
                     count_in     = count_ff - 1'b1;
                     tx_seq_in    = ~tx_seq_ff;
                     in_flight_in = 1'b0;
                     timer_in     = '0;
                     if (count_ff != COUNT_BITS'(1)) begin
                        flags.link_valid    = 1'b1;
                        flags.link_seq      = ~tx_seq_ff;
                        flags.link_from_ram = 1'b1;
                        rd_en               = 1'b1;
                        rd_addr             = head_next;
                        in_flight_in        = 1'b1;
                     end
                  end
               end else begin
                  flags.link_valid  = 1'b1;
                  flags.link_is_ack = 1'b1;
                  flags.link_seq    = rx_bit_ff;
                  if (!data_seen_ff || data_bit_ff != frame_seq) begin
                     data_seen_in        = 1'b1;
                     data_bit_in         = frame_seq;
                     rx_bit_in           = ~rx_bit_ff;
                     flags.link_seq      = ~rx_bit_ff;
                     flags.deliver_valid = 1'b1;
                     deliver_payload     = payload;
                  end
               end
            end
            OP_TICK: begin
               if (in_flight_ff && count_ff != '0) begin
                  timer_in = timer_inc;
                  if (timer_inc >= timeout_ff) begin
                     flags.link_valid    = 1'b1;
                     flags.link_seq      = tx_seq_ff;
                     flags.link_from_ram = 1'b1;
                     rd_en               = 1'b1;
                     timer_in            = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         tx_seq_ff    <= 1'b0;
         in_flight_ff <= 1'b0;
         timer_ff     <= '0;
         ack_seen_ff  <= 1'b0;
         ack_bit_ff   <= 1'b0;
         data_seen_ff <= 1'b0;
         data_bit_ff  <= 1'b0;
         rx_bit_ff    <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         tx_seq_ff    <= tx_seq_in;
         in_flight_ff <= in_flight_in;
         timer_ff     <= timer_in;
         ack_seen_ff  <= ack_seen_in;
         ack_bit_ff   <= ack_bit_in;
         data_seen_ff <= data_seen_in;
         data_bit_ff  <= data_bit_in;
         rx_bit_ff    <= rx_bit_in;
      end
   end

`ifndef ASSERT_OFF
   a_flight_needs_entry: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff |-> count_ff != '0)
      else $error("frame in flight with an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("queue count beyond depth");

   a_drop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      accept && operation == OP_PACKET && count_ff == COUNT_FULL
      |=> count_ff == $past(count_ff))
      else $error("dropped request changed the queue count");
`endif

endmodule

### sv/stop_and_wait_arq_link.sv
// Top level of the stop-and-wait ARQ link end: controller, send queue RAM
// and the result register. Depends on sawl_pkg, sawl_ctrl and sawl_ram.
//
// Requests enter on the req_ channel: an upper-layer packet, a frame from the
// link or a timer tick. Each accepted request gives exactly one result on the
// rsp_ channel: a frame to send on the link, a payload delivered upward and a
// drop flag for a packet that found the queue full.
// A result appears in the cycle after its request is accepted, and one request
// can be accepted in every cycle while req_stall is low; the result register is the only stage.
// Queued payloads live in a RAM with a registered read; a retransmitted or
// next-in-line frame takes its payload from that read port.
// The retransmit timeout is written on the csr_ port (reset value 5 ticks).
// Reset empties the queue and clears the sequence state; the queue contents
// are not cleared.
// While a result waits and rsp_stall is high, the result holds and req_stall
// is raised, so no request is taken until the result has gone.
module stop_and_wait_arq_link #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic                            req_frame_is_ack,
   input  logic                            req_frame_seq,
   input  logic [PAYLOAD_BITS-1:0]         req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_link_valid,
   output logic                            rsp_link_is_ack,
   output logic                            rsp_link_seq,
   output logic [PAYLOAD_BITS-1:0]         rsp_link_payload,
   output logic                            rsp_deliver_valid,
   output logic [PAYLOAD_BITS-1:0]         rsp_deliver_payload,
   output logic                            rsp_dropped,
   input  logic                            csr_write_enable,
   input  logic [sawl_pkg::TIMER_BITS-1:0] csr_write_data
);

   import sawl_pkg::*;

   localparam int ADDR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic                    accept;
   result_flags_type        flags;
   logic [PAYLOAD_BITS-1:0] link_payload;
   logic [PAYLOAD_BITS-1:0] deliver_payload;
   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [PAYLOAD_BITS-1:0] wr_data;
   logic                    rd_en;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [PAYLOAD_BITS-1:0] rd_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   result_flags_type        flags_ff;
   logic [PAYLOAD_BITS-1:0] link_payload_ff;
   logic [PAYLOAD_BITS-1:0] deliver_payload_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   sawl_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .operation        (req_operation),
      .frame_is_ack     (req_frame_is_ack),
      .frame_seq        (req_frame_seq),
      .payload          (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .flags            (flags),
      .link_payload     (link_payload),
      .deliver_payload  (deliver_payload),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr)
   );

   sawl_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff           <= flags;
         link_payload_ff    <= link_payload;
         deliver_payload_ff <= deliver_payload;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_link_valid      = flags_ff.link_valid;
   assign rsp_link_is_ack     = flags_ff.link_is_ack;
   assign rsp_link_seq        = flags_ff.link_seq;
   assign rsp_link_payload    = flags_ff.link_from_ram ? rd_data : link_payload_ff;
   assign rsp_deliver_valid   = flags_ff.deliver_valid;
   assign rsp_deliver_payload = deliver_payload_ff;
   assign rsp_dropped         = flags_ff.dropped;

`ifndef ASSERT_OFF
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result waiting");

   a_deliver_acked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deliver_valid |-> rsp_link_valid && rsp_link_is_ack)
      else $error("delivery without an acknowledgement");

   a_drop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_link_valid && !rsp_deliver_valid)
      else $error("dropped request produced traffic");
`endif

endmodule
